/* design/s2l_pkg.sv */
// ----------------------------------------------------------------------------
// s2l_pkg: shared types, constants and table builders
// Fixed-point formats, pipeline stage counts and the constant functions that
// fill the sRGB linearization ROM and the cube-root ROM at elaboration.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int OUT_FRAC_BITS_DEFAULT = 8;
  localparam int TABLE_BITS_DEFAULT    = 8;

  localparam int CHAN_W  = 8;   // one gamma-encoded channel
  localparam int Q_W     = 17;  // unsigned Q16 values from 0 to 1.0 inclusive
  localparam int LIGHT_W = 15;
  localparam int AXIS_W  = 16;

  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  typedef logic [Q_W-1:0] q_t;

  // Register stages of each section, in pipeline order.
  localparam int LIN_STAGES   = 1;
  localparam int XYZ_STAGES   = 6;
  localparam int LABF_STAGES  = 5;
  localparam int LAB_STAGES   = LABF_STAGES + 2;
  localparam int PIPE_LATENCY = LIN_STAGES + XYZ_STAGES + LAB_STAGES;

  // Largest lightness code for a given number of fraction bits.
  function automatic int light_max(input int ofb);
    int full;
    full = 100 << ofb;
    return (full > 32767) ? 32767 : full;
  endfunction

  // Linear-light value of one 8-bit sRGB code in Q16. Only called with
  // constant arguments to fill the ROM.
  function automatic q_t lin_value(input int unsigned code);
    logic [63:0]  t;
    logic [63:0]  s;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  v;
    logic [127:0] p5;
    logic [127:0] lim;
    int i;
    t   = 64'd0;
    s   = 64'd0;
    lo  = 64'd0;
    hi  = 64'd65536;
    mid = 64'd0;
    p5  = 128'd0;
    lim = 128'd0;
    if (code <= 10) begin
      v = (64'(code) * 64'd6553600 + 64'd164730) / 64'd329460;
    end else begin
      t   = ((64'(code) * 64'd1000 + 64'd14025) * 64'd65536 + 64'd134512) / 64'd269025;
      s   = t * t;
      lim = {64'd0, s} << 48;
      // Exact fifth root of s * 2^48 by bisection.
      for (i = 0; i < 20; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p5  = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid);
          if (p5 <= lim) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      v = (s * lo + 64'h8000_0000) >> 32;
    end
    return Q_W'(v);
  endfunction

  // Cube-root table entry k for a table indexed by the top tbits of a Q16 value.
  function automatic q_t cube_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int i;
    target = 64'(k) << (48 - tbits);
    lo     = 64'd0;
    hi     = 64'd65536;
    mid    = 64'd0;
    for (i = 0; i < 20; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return Q_W'(lo);
  endfunction

endpackage

/* design/s2l_linrom.sv */
// ----------------------------------------------------------------------------
// s2l_linrom: sRGB linearization ROM
// 256-entry constant table from an 8-bit code to linear light in Q16, with a
// registered read.
// ----------------------------------------------------------------------------
module s2l_linrom
  import s2l_pkg::*;
(
  input  logic              clk,
  input  logic [CHAN_W-1:0] code,
  output q_t                level
);

  localparam int ROM_N = 2 ** CHAN_W;

  q_t lin_rom [ROM_N];

  for (genvar c = 0; c < ROM_N; c++) begin : g_entry
    localparam q_t ENTRY = lin_value(c);
    assign lin_rom[c] = ENTRY;
  end

  always_ff @(posedge clk) begin
    level <= lin_rom[code];
  end

endmodule

/* design/s2l_cdiv.sv */
// ----------------------------------------------------------------------------
// s2l_cdiv: pipelined division by a constant
// Floor quotient through a reciprocal multiply, a back multiply and one
// compare-and-increment correction; three register stages.
// ----------------------------------------------------------------------------
module s2l_cdiv
  import s2l_pkg::*;
#(
  parameter int              N_W     = 33,
  parameter longint unsigned DIVISOR = 64'd95047
) (
  input  logic                          clk,
  input  logic [N_W-1:0]                num,
  output logic [N_W-$clog2(DIVISOR):0]  quo
);

  localparam int              M_W     = N_W - $clog2(DIVISOR) + 1;
  localparam int              D_W     = $clog2(DIVISOR + 1);
  localparam int              E_W     = N_W + M_W;
  localparam int              P_W     = M_W + D_W;
  localparam longint unsigned RECIP   = (64'd1 << N_W) / DIVISOR;
  localparam logic [M_W-1:0]  RECIP_C = M_W'(RECIP);
  localparam logic [D_W-1:0]  DIV_C   = D_W'(DIVISOR);

  logic [E_W-1:0] est_prod;
  logic [N_W-1:0] num_d1;
  logic [N_W-1:0] num_d2;
  logic [M_W-1:0] est;
  logic [P_W-1:0] back_prod;
  logic [P_W-1:0] rem;

  // The estimate is the true quotient or one less, so the remainder is
  // below twice the divisor.
  assign rem = P_W'(num_d2) - back_prod;

  always_ff @(posedge clk) begin
    est_prod  <= E_W'(num) * E_W'(RECIP_C);
    num_d1    <= num;
    est       <= est_prod[E_W-1:N_W];
    back_prod <= P_W'(est_prod[E_W-1:N_W]) * P_W'(DIV_C);
    num_d2    <= num_d1;
    quo       <= (rem >= P_W'(DIV_C)) ? est + M_W'(1) : est;
  end

endmodule

/* design/s2l_xyz.sv */
// ----------------------------------------------------------------------------
// s2l_xyz: RGB to white-normalized XYZ
// Nine constant products, three sums with rounding, three constant dividers
// and a clamp to 1.0; six register stages.
// ----------------------------------------------------------------------------
module s2l_xyz
  import s2l_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  q_t   red_lin,
  input  q_t   green_lin,
  input  q_t   blue_lin,
  output logic out_valid,
  output q_t   x_norm,
  output q_t   y_norm,
  output q_t   z_norm
);

  localparam int XN_W = 33;
  localparam int YN_W = 30;
  localparam int ZN_W = 33;

  // X and Z rows carry the factor of ten of the white-point division.
  localparam logic [XN_W-1:0] X_R = 33'd41240;
  localparam logic [XN_W-1:0] X_G = 33'd35760;
  localparam logic [XN_W-1:0] X_B = 33'd18050;
  localparam logic [YN_W-1:0] Y_R = 30'd2126;
  localparam logic [YN_W-1:0] Y_G = 30'd7152;
  localparam logic [YN_W-1:0] Y_B = 30'd722;
  localparam logic [ZN_W-1:0] Z_R = 33'd1930;
  localparam logic [ZN_W-1:0] Z_G = 33'd11920;
  localparam logic [ZN_W-1:0] Z_B = 33'd95050;

  localparam longint unsigned X_DIV = 95047;
  localparam longint unsigned Y_DIV = 10000;
  localparam longint unsigned Z_DIV = 108883;
  localparam logic [XN_W-1:0] X_RND = 33'd47523;
  localparam logic [YN_W-1:0] Y_RND = 30'd5000;
  localparam logic [ZN_W-1:0] Z_RND = 33'd54441;

  localparam int XQ_W = XN_W - $clog2(X_DIV) + 1;
  localparam int YQ_W = YN_W - $clog2(Y_DIV) + 1;
  localparam int ZQ_W = ZN_W - $clog2(Z_DIV) + 1;

  logic [XYZ_STAGES-1:0] vld;

  logic [XN_W-1:0] px_r, px_g, px_b, nx;
  logic [YN_W-1:0] py_r, py_g, py_b, ny;
  logic [ZN_W-1:0] pz_r, pz_g, pz_b, nz;
  logic [XQ_W-1:0] qx;
  logic [YQ_W-1:0] qy;
  logic [ZQ_W-1:0] qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[XYZ_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    px_r <= XN_W'(red_lin) * X_R;
    px_g <= XN_W'(green_lin) * X_G;
    px_b <= XN_W'(blue_lin) * X_B;
    py_r <= YN_W'(red_lin) * Y_R;
    py_g <= YN_W'(green_lin) * Y_G;
    py_b <= YN_W'(blue_lin) * Y_B;
    pz_r <= ZN_W'(red_lin) * Z_R;
    pz_g <= ZN_W'(green_lin) * Z_G;
    pz_b <= ZN_W'(blue_lin) * Z_B;
    nx   <= px_r + px_g + px_b + X_RND;
    ny   <= py_r + py_g + py_b + Y_RND;
    nz   <= pz_r + pz_g + pz_b + Z_RND;
  end

  s2l_cdiv #(.N_W(XN_W), .DIVISOR(X_DIV)) u_div_x (.clk(clk), .num(nx), .quo(qx));
  s2l_cdiv #(.N_W(YN_W), .DIVISOR(Y_DIV)) u_div_y (.clk(clk), .num(ny), .quo(qy));
  s2l_cdiv #(.N_W(ZN_W), .DIVISOR(Z_DIV)) u_div_z (.clk(clk), .num(nz), .quo(qz));

  // Colors brighter than the white point are held at 1.0.
  always_ff @(posedge clk) begin
    x_norm <= (qx > XQ_W'(Q_ONE)) ? Q_ONE : Q_W'(qx);
    y_norm <= (qy > YQ_W'(Q_ONE)) ? Q_ONE : Q_W'(qy);
    z_norm <= (qz > ZQ_W'(Q_ONE)) ? Q_ONE : Q_W'(qz);
  end

  assign out_valid = vld[XYZ_STAGES-1];

endmodule

/* design/s2l_labf.sv */
// ----------------------------------------------------------------------------
// s2l_labf: CIELAB companding function f(t)
// Cube root from an interpolated ROM above the knee, linear segment below it;
// five register stages.
// ----------------------------------------------------------------------------
module s2l_labf
  import s2l_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEFAULT
) (
  input  logic clk,
  input  q_t   t_in,
  output q_t   f_out
);

  localparam int FRAC_W  = Q_W - 1 - TABLE_BITS;
  localparam int IDX_W   = TABLE_BITS + 1;
  localparam int ENTRIES = 2 ** TABLE_BITS + 2;
  localparam int IP_W    = Q_W + FRAC_W;
  localparam logic [IP_W-1:0] HALF = IP_W'(1) << (FRAC_W - 1);

  // Knee: t * 10^6 <= 8856 * 65536.
  localparam int LIN_MAX = 580386816 / 1000000;
  localparam int LT_W    = 10;
  localparam int LN_W    = 31;
  localparam logic [LN_W-1:0] LIN_SLOPE = 31'd903292;
  localparam logic [LN_W-1:0] LIN_OFS   = 31'd1048634000;
  localparam longint unsigned LIN_DIV   = 116000;
  localparam int LQ_W = LN_W - $clog2(LIN_DIV) + 1;

  q_t cube_rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam q_t ENTRY = cube_entry(k, TABLE_BITS);
    assign cube_rom[k] = ENTRY;
  end

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_up;
  q_t                e0, e1, base2, ires3, ires4;
  logic [FRAC_W-1:0] frac1;
  logic [IP_W-1:0]   ip2;
  logic [IP_W-1:0]   ip_rnd;
  logic              lin1, lin2, lin3, lin4;
  logic [LN_W-1:0]   lnum;
  logic [LQ_W-1:0]   lq;

  assign idx    = t_in[Q_W-1:FRAC_W];
  assign idx_up = idx + IDX_W'(1);
  assign ip_rnd = ip2 + HALF;

  always_ff @(posedge clk) begin
    e0    <= cube_rom[idx];
    e1    <= cube_rom[idx_up];
    frac1 <= t_in[FRAC_W-1:0];
    lin1  <= (t_in <= Q_W'(LIN_MAX));
    lnum  <= LN_W'(t_in[LT_W-1:0]) * LIN_SLOPE + LIN_OFS;

    ip2   <= IP_W'(e1 - e0) * IP_W'(frac1);
    base2 <= e0;
    lin2  <= lin1;

    ires3 <= base2 + ip_rnd[IP_W-1:FRAC_W];
    lin3  <= lin2;

    ires4 <= ires3;
    lin4  <= lin3;

    f_out <= lin4 ? Q_W'(lq) : ires4;
  end

  s2l_cdiv #(.N_W(LN_W), .DIVISOR(LIN_DIV)) u_div_lin (.clk(clk), .num(lnum), .quo(lq));

endmodule

/* design/s2l_lab.sv */
// ----------------------------------------------------------------------------
// s2l_lab: f(t) on three components and the L, a, b output stage
// Scales the differences, rounds to the output grid and saturates.
// ----------------------------------------------------------------------------
module s2l_lab
  import s2l_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEFAULT,
  parameter int TABLE_BITS    = TABLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  q_t                       x_norm,
  input  q_t                       y_norm,
  input  q_t                       z_norm,
  output logic                     done,
  output logic [LIGHT_W-1:0]       lightness,
  output logic signed [AXIS_W-1:0] green_red_axis,
  output logic signed [AXIS_W-1:0] blue_yellow_axis
);

  localparam int P_W = 28;
  localparam int SH  = Q_W - 1 - OUT_FRAC_BITS;
  localparam logic [P_W-1:0]        HALF   = P_W'(1) << (SH - 1);
  localparam logic signed [P_W-1:0] L_MUL  = P_W'(116);
  localparam logic signed [P_W-1:0] L_OFS  = P_W'(16 * 65536);
  localparam logic signed [P_W-1:0] A_MUL  = P_W'(500);
  localparam logic signed [P_W-1:0] B_MUL  = P_W'(200);
  localparam logic signed [P_W-1:0] L_TOP  = P_W'(light_max(OUT_FRAC_BITS));
  localparam logic signed [P_W-1:0] AX_MAX = P_W'(32767);
  localparam logic signed [P_W-1:0] AX_MIN = P_W'(-32768);

  logic [LAB_STAGES-1:0] vld;
  q_t fx, fy, fz;
  logic signed [P_W-1:0] fx_s, fy_s, fz_s;
  logic signed [P_W-1:0] lprod, aprod, bprod;
  logic signed [P_W-1:0] lr, ar, br;

  // Round half away from zero, then drop SH fraction bits.
  function automatic logic signed [P_W-1:0] round_out(input logic signed [P_W-1:0] v);
    logic [P_W-1:0] mag;
    logic [P_W-1:0] r;
    mag = v[P_W-1] ? P_W'(-v) : P_W'(v);
    r   = (mag + HALF) >> SH;
    return v[P_W-1] ? -signed'(r) : signed'(r);
  endfunction

  s2l_labf #(.TABLE_BITS(TABLE_BITS)) u_f_x (.clk(clk), .t_in(x_norm), .f_out(fx));
  s2l_labf #(.TABLE_BITS(TABLE_BITS)) u_f_y (.clk(clk), .t_in(y_norm), .f_out(fy));
  s2l_labf #(.TABLE_BITS(TABLE_BITS)) u_f_z (.clk(clk), .t_in(z_norm), .f_out(fz));

  assign fx_s = signed'(P_W'(fx));
  assign fy_s = signed'(P_W'(fy));
  assign fz_s = signed'(P_W'(fz));

  always_comb begin
    lr = round_out(lprod);
    ar = round_out(aprod);
    br = round_out(bprod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAB_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    lprod <= fy_s * L_MUL - L_OFS;
    aprod <= (fx_s - fy_s) * A_MUL;
    bprod <= (fy_s - fz_s) * B_MUL;

    if (lr < 0) begin
      lightness <= '0;
    end else if (lr > L_TOP) begin
      lightness <= L_TOP[LIGHT_W-1:0];
    end else begin
      lightness <= lr[LIGHT_W-1:0];
    end

    if (ar > AX_MAX) begin
      green_red_axis <= AX_MAX[AXIS_W-1:0];
    end else if (ar < AX_MIN) begin
      green_red_axis <= AX_MIN[AXIS_W-1:0];
    end else begin
      green_red_axis <= ar[AXIS_W-1:0];
    end

    if (br > AX_MAX) begin
      blue_yellow_axis <= AX_MAX[AXIS_W-1:0];
    end else if (br < AX_MIN) begin
      blue_yellow_axis <= AX_MIN[AXIS_W-1:0];
    end else begin
      blue_yellow_axis <= br[AXIS_W-1:0];
    end
  end

  assign done = vld[LAB_STAGES-1];

endmodule

/* design/srgb_to_cielab.sv */
// ----------------------------------------------------------------------------
// srgb_to_cielab: 8-bit sRGB pixel to fixed-point CIELAB (D65)
// Throughput: one pixel per clock; busy is low whenever rst is low.
// Results: each pixel taken at a rising edge comes out on the outputs, with
// done high for one cycle, once it has passed through every pipeline stage.
// Reset: synchronous rst empties every pipeline stage; beats in flight are
// dropped and no result appears until new pixels arrive.
// ----------------------------------------------------------------------------
module srgb_to_cielab
  import s2l_pkg::*;
#(
  parameter int OUT_FRAC_BITS        = OUT_FRAC_BITS_DEFAULT,
  parameter int CUBE_ROOT_TABLE_BITS = TABLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CHAN_W-1:0]        red,
  input  logic [CHAN_W-1:0]        green,
  input  logic [CHAN_W-1:0]        blue,
  output logic                     done,
  output logic [LIGHT_W-1:0]       lightness,
  output logic signed [AXIS_W-1:0] green_red_axis,
  output logic signed [AXIS_W-1:0] blue_yellow_axis
);

  // The pipeline never stalls: every stage advances each clock, so the only
  // time a beat cannot be taken is while reset is applied.
  assign busy = rst;

  logic accept;
  logic lin_valid;
  logic xyz_valid;
  q_t   red_lin, green_lin, blue_lin;
  q_t   x_norm, y_norm, z_norm;

  assign accept = start && !busy;

  // Stage 1: each channel looks up its linear-light value in its own ROM.
  // The ROM read is registered, so the beat's valid bit is registered here
  // alongside it.
  s2l_linrom u_lin_red   (.clk(clk), .code(red),   .level(red_lin));
  s2l_linrom u_lin_green (.clk(clk), .code(green), .level(green_lin));
  s2l_linrom u_lin_blue  (.clk(clk), .code(blue),  .level(blue_lin));

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_valid <= 1'b0;
    end else begin
      lin_valid <= accept;
    end
  end

  // Stages 2 to 7: the RGB-to-XYZ matrix, the division by the white point
  // done as reciprocal multiplies with an exact correction step, and the
  // clamp of over-white components to 1.0.
  s2l_xyz u_xyz (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lin_valid),
    .red_lin   (red_lin),
    .green_lin (green_lin),
    .blue_lin  (blue_lin),
    .out_valid (xyz_valid),
    .x_norm    (x_norm),
    .y_norm    (y_norm),
    .z_norm    (z_norm)
  );

  // Stages 8 to 14: f(t) on each component (interpolated cube-root ROM or
  // the linear segment near black), then L, a and b scaled, rounded half
  // away from zero to OUT_FRAC_BITS fraction bits, and saturated. The last
  // stage is the output register that done qualifies.
  s2l_lab #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .TABLE_BITS    (CUBE_ROOT_TABLE_BITS)
  ) u_lab (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (xyz_valid),
    .x_norm           (x_norm),
    .y_norm           (y_norm),
    .z_norm           (z_norm),
    .done             (done),
    .lightness        (lightness),
    .green_red_axis   (green_red_axis),
    .blue_yellow_axis (blue_yellow_axis)
  );

endmodule

/* design/s2l_checker.sv */
// ----------------------------------------------------------------------------
// s2l_checker: port-level checks for srgb_to_cielab
// Result timing against accepted beats, lightness range, and the black and
// white end points.
// ----------------------------------------------------------------------------
module s2l_checker
  import s2l_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEFAULT
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [CHAN_W-1:0]        red,
  input logic [CHAN_W-1:0]        green,
  input logic [CHAN_W-1:0]        blue,
  input logic                     done,
  input logic [LIGHT_W-1:0]       lightness,
  input logic signed [AXIS_W-1:0] green_red_axis,
  input logic signed [AXIS_W-1:0] blue_yellow_axis
);

  localparam logic [LIGHT_W-1:0] L_TOP = LIGHT_W'(light_max(OUT_FRAC_BITS));

  logic accept;
  logic black_in;
  logic white_in;

  assign accept   = start && !busy;
  assign black_in = accept && red == 8'h00 && green == 8'h00 && blue == 8'h00;
  assign white_in = accept && red == 8'hFF && green == 8'hFF && blue == 8'hFF;

  // Every result belongs to an accepted beat, found through $past at the full pipeline depth.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LATENCY))
    else $error("result beat without a matching input beat");

  a_light_range: assert property (@(posedge clk) disable iff (rst)
    done |-> lightness <= L_TOP)
    else $error("lightness above its saturation limit");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && $past(black_in, PIPE_LATENCY)) |->
      (lightness == '0 && green_red_axis == '0 && blue_yellow_axis == '0))
    else $error("black pixel did not give L = a = b = 0");

  a_white: assert property (@(posedge clk) disable iff (rst)
    (done && $past(white_in, PIPE_LATENCY)) |->
      (lightness == L_TOP && green_red_axis == '0 && blue_yellow_axis == '0))
    else $error("white pixel did not give full lightness with zero chroma");

endmodule

bind srgb_to_cielab s2l_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_checker (.*);
